// ----- rtl/core/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority ready queue package
// Shared field widths, operation and status codes, sequencer states and
// the result record passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int unsigned TASK_ID_W = 3;
    localparam int unsigned LEVEL_W   = 4;
    localparam int unsigned STATUS_W  = 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_MISSING  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_LINK = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [TASK_ID_W-1:0] top_task;
        logic                 any_ready;
        logic [STATUS_W-1:0]  status;
    } t_result;

endpackage

// ----- rtl/core/prq_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one insert or remove request.
// ----------------------------------------------------------------------------
interface prq_req_if import prq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [TASK_ID_W-1:0] task_id;
    logic [LEVEL_W-1:0]   level;

    modport source (output valid, output cmd, output task_id, output level, input ready);
    modport sink   (input valid, input cmd, input task_id, input level, output ready);

endinterface

// ----- rtl/core/prq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the queue report that follows each request.
// ----------------------------------------------------------------------------
interface prq_rsp_if import prq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [TASK_ID_W-1:0] top_task;
    logic                 any_ready;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output top_task, output any_ready, output status,
                    input ready);
    modport sink   (input valid, input top_task, input any_ready, input status,
                    output ready);

endinterface

// ----- rtl/core/priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// Priority ready queue
// Task ready queue with one FIFO per priority level, reporting the head of
// the lowest-numbered non-empty level after every request.
//
// i_req carries requests: cmd 0 inserts task_id at the tail of level (levels
// at or above NUM_LEVELS go to the last level), cmd 1 removes task_id from
// wherever it stands. o_rsp returns one report per request: top_task, the
// head of the lowest-numbered non-empty level (0 if none), any_ready, and
// status (0 done, 1 insert of a queued task dropped, 2 remove of an
// unqueued task dropped).
// One request is in work at a time. A carried-out request passes the link
// update and then the level scan, one level per cycle; a dropped one goes
// straight to the scan.
// The report sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds back the block only once a second
// report is ready. Reset empties every level at once.
// ----------------------------------------------------------------------------
module priority_ready_queue import prq_pkg::*; #(
    parameter int unsigned NUM_TASKS  = 8,
    parameter int unsigned NUM_LEVELS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prq_req_if.sink     i_req,
    prq_rsp_if.source   o_rsp
);

    logic    done;
    logic    taken;
    t_result result;
    logic    r_valid, n_valid;
    t_result r_result, n_result;

    prq_ctrl #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .i_req_cmd     (i_req.cmd),
        .i_req_task_id (i_req.task_id),
        .i_req_level   (i_req.level),
        .o_req_ready   (i_req.ready),
        .o_done        (done),
        .o_result      (result),
        .i_taken       (taken)
    );

    assign taken = done && (!r_valid || o_rsp.ready);

    always_comb begin
        n_valid  = r_valid;
        n_result = r_result;
        if (taken) begin
            n_valid  = 1'b1;
            n_result = result;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.top_task  = r_result.top_task;
    assign o_rsp.any_ready = r_result.any_ready;
    assign o_rsp.status    = r_result.status;

endmodule

// ----- rtl/core/prq_ram.sv -----
// ----------------------------------------------------------------------------
// Queue link memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned WIDTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/prq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Queue sequencer
// Steps each request through link update and a level-by-level scan for the
// first non-empty level, using link memories with one write and one read port.
// ----------------------------------------------------------------------------
module prq_ctrl import prq_pkg::*; #(
    parameter int unsigned NUM_TASKS  = 8,
    parameter int unsigned NUM_LEVELS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_cmd,
    input  logic [TASK_ID_W-1:0] i_req_task_id,
    input  logic [LEVEL_W-1:0]   i_req_level,
    output logic                 o_req_ready,
    output logic                 o_done,
    output t_result              o_result,
    input  logic                 i_taken
);

    localparam int unsigned TW = $clog2(NUM_TASKS);
    localparam int unsigned LW = $clog2(NUM_TASKS + 1);
    localparam int unsigned VW = $clog2(NUM_LEVELS);
    localparam logic [LW-1:0] NO_LINK    = LW'(NUM_TASKS);
    localparam logic [VW-1:0] LAST_LEVEL = VW'(NUM_LEVELS - 1);

    t_state                r_state, n_state;
    logic                  r_cmd, n_cmd;
    logic [TASK_ID_W-1:0]  r_task, n_task;
    logic [VW-1:0]         r_lvl, n_lvl;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_found, n_found;
    logic [VW-1:0]         r_idx, n_idx;
    logic [NUM_TASKS-1:0]  r_queued, n_queued;
    logic [NUM_LEVELS-1:0] r_nonempty, n_nonempty;

    logic                  accept;
    logic [VW-1:0]         req_lvl;
    logic [TW-1:0]         req_idx;
    logic                  req_task_ok;
    logic [TW-1:0]         t_idx;

    logic                  tl_we, nx_we, pv_we, lh_we, lt_we;
    logic [TW-1:0]         tl_waddr, nx_waddr, pv_waddr;
    logic [VW-1:0]         lh_waddr, lt_waddr;
    logic [VW-1:0]         tl_wdata;
    logic [LW-1:0]         nx_wdata, pv_wdata;
    logic [TW-1:0]         lh_wdata, lt_wdata;
    logic                  lh_re;
    logic [VW-1:0]         tl_rdata;
    logic [LW-1:0]         nx_rdata, pv_rdata;
    logic [TW-1:0]         lh_rdata, lt_rdata;

    logic [VW-1:0]         rm_lvl;
    logic                  p_ok, n_ok;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign req_lvl     = (int'(i_req_level) >= NUM_LEVELS) ? LAST_LEVEL : VW'(i_req_level);
    assign req_idx     = TW'(i_req_task_id);
    assign req_task_ok = int'(i_req_task_id) < NUM_TASKS;
    assign t_idx       = TW'(r_task);

    assign rm_lvl = tl_rdata;
    assign p_ok   = int'(pv_rdata) < NUM_TASKS;
    assign n_ok   = int'(nx_rdata) < NUM_TASKS;

    prq_ram #(.DEPTH(NUM_TASKS), .WIDTH(VW)) u_task_level (
        .i_clk   (i_clk),
        .i_we    (tl_we),
        .i_waddr (tl_waddr),
        .i_wdata (tl_wdata),
        .i_re    (accept),
        .i_raddr (req_idx),
        .o_rdata (tl_rdata)
    );

    prq_ram #(.DEPTH(NUM_TASKS), .WIDTH(LW)) u_next_link (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (accept),
        .i_raddr (req_idx),
        .o_rdata (nx_rdata)
    );

    prq_ram #(.DEPTH(NUM_TASKS), .WIDTH(LW)) u_prev_link (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_re    (accept),
        .i_raddr (req_idx),
        .o_rdata (pv_rdata)
    );

    prq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(TW)) u_level_head (
        .i_clk   (i_clk),
        .i_we    (lh_we),
        .i_waddr (lh_waddr),
        .i_wdata (lh_wdata),
        .i_re    (lh_re),
        .i_raddr (r_idx),
        .o_rdata (lh_rdata)
    );

    prq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(TW)) u_level_tail (
        .i_clk   (i_clk),
        .i_we    (lt_we),
        .i_waddr (lt_waddr),
        .i_wdata (lt_wdata),
        .i_re    (accept),
        .i_raddr (req_lvl),
        .o_rdata (lt_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_task     = r_task;
        n_lvl      = r_lvl;
        n_status   = r_status;
        n_found    = r_found;
        n_idx      = r_idx;
        n_queued   = r_queued;
        n_nonempty = r_nonempty;

        tl_we    = 1'b0;
        tl_waddr = t_idx;
        tl_wdata = r_lvl;
        nx_we    = 1'b0;
        nx_waddr = t_idx;
        nx_wdata = NO_LINK;
        pv_we    = 1'b0;
        pv_waddr = t_idx;
        pv_wdata = NO_LINK;
        lh_we    = 1'b0;
        lh_waddr = r_lvl;
        lh_wdata = t_idx;
        lt_we    = 1'b0;
        lt_waddr = r_lvl;
        lt_wdata = t_idx;
        lh_re    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_req_cmd;
                    n_task  = i_req_task_id;
                    n_lvl   = req_lvl;
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (i_req_cmd == CMD_INSERT) begin
                        n_status = (!req_task_ok || r_queued[req_idx]) ?
                                   STATUS_DUPLICATE : STATUS_DONE;
                    end else begin
                        n_status = (!req_task_ok || !r_queued[req_idx]) ?
                                   STATUS_MISSING : STATUS_DONE;
                    end
                    n_state = (n_status == STATUS_DONE) ? ST_EXEC : ST_SCAN;
                end
            end
            ST_EXEC: begin
                if (r_cmd == CMD_INSERT) begin
                    tl_we = 1'b1;
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                    pv_wdata = r_nonempty[r_lvl] ? LW'(lt_rdata) : NO_LINK;
                    lt_we = 1'b1;
                    lh_we = !r_nonempty[r_lvl];
                    n_queued[t_idx]   = 1'b1;
                    n_nonempty[r_lvl] = 1'b1;
                    n_state = r_nonempty[r_lvl] ? ST_LINK : ST_SCAN;
                end else begin
                    // unlink: join the predecessor and successor around the task
                    nx_we    = p_ok;
                    nx_waddr = TW'(pv_rdata);
                    nx_wdata = nx_rdata;
                    pv_we    = n_ok;
                    pv_waddr = TW'(nx_rdata);
                    pv_wdata = pv_rdata;
                    lh_we    = !p_ok && n_ok;
                    lh_waddr = rm_lvl;
                    lh_wdata = TW'(nx_rdata);
                    lt_we    = !n_ok && p_ok;
                    lt_waddr = rm_lvl;
                    lt_wdata = TW'(pv_rdata);
                    if (!p_ok && !n_ok) begin
                        n_nonempty[rm_lvl] = 1'b0;
                    end
                    n_queued[t_idx] = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_LINK: begin
                nx_we    = 1'b1;
                nx_waddr = lt_rdata;
                nx_wdata = LW'(t_idx);
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_nonempty[r_idx]) begin
                    lh_re   = 1'b1;
                    n_found = 1'b1;
                    n_state = ST_OUT;
                end else if (r_idx == LAST_LEVEL) begin
                    n_state = ST_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_OUT: begin
                if (i_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done             = (r_state == ST_OUT);
    assign o_result.top_task  = r_found ? TASK_ID_W'(lh_rdata) : '0;
    assign o_result.any_ready = r_found;
    assign o_result.status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_queued   <= '0;
            r_nonempty <= '0;
        end else begin
            r_state    <= n_state;
            r_queued   <= n_queued;
            r_nonempty <= n_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_task   <= n_task;
        r_lvl    <= n_lvl;
        r_status <= n_status;
        r_found  <= n_found;
        r_idx    <= n_idx;
    end

endmodule

// ----- verif/prq_queue_check.sv -----
// ----------------------------------------------------------------------------
// Priority ready queue report check
// Watches the request and report channels, keeps its own list of queued
// tasks in insertion order and predicts each report from it: the head of a
// level is its oldest entry, and the top task comes from the lowest level
// that holds one. Reports are compared field by field, in order.
// ----------------------------------------------------------------------------
module prq_queue_check import prq_pkg::*; #(
    parameter int unsigned NUM_TASKS  = 8,
    parameter int unsigned NUM_LEVELS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    prq_req_if   i_req,
    prq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef logic [TASK_ID_W-1:0] t_task;
    typedef logic [LEVEL_W-1:0]   t_level;

    typedef struct packed {
        t_task  id;
        t_level lvl;
    } t_queued_task;

    t_queued_task queued_tasks[$];
    t_result      expected_reports[$];
    int           mismatches = 0;

    function automatic t_result apply_request(t_cmd op, t_task id, t_level lvl);
        t_result      rpt;
        t_queued_task entry;
        int           found;
        int           best;
        found = -1;
        foreach (queued_tasks[i])
            if (queued_tasks[i].id == id) found = i;
        rpt.status = STATUS_DONE;
        if (op == CMD_INSERT) begin
            if (found >= 0 || id >= NUM_TASKS) begin
                rpt.status = STATUS_DUPLICATE;
            end else begin
                entry.id  = id;
                entry.lvl = (lvl >= NUM_LEVELS) ? t_level'(NUM_LEVELS - 1) : lvl;
                queued_tasks.push_back(entry);
            end
        end else begin
            if (found < 0) rpt.status = STATUS_MISSING;
            else queued_tasks.delete(found);
        end
        best = -1;
        foreach (queued_tasks[i])
            if (best < 0 || queued_tasks[i].lvl < queued_tasks[best].lvl) best = i;
        rpt.any_ready = (best >= 0);
        rpt.top_task  = (best >= 0) ? queued_tasks[best].id : t_task'(0);
        return rpt;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            queued_tasks.delete();
            expected_reports.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                expected_reports.push_back(apply_request(t_cmd'(i_req.cmd), i_req.task_id,
                                                         i_req.level));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: report with none expected: top_task %0d any_ready %0d status %0d",
                             $time, i_rsp.top_task, i_rsp.any_ready, i_rsp.status);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_rsp.top_task !== want.top_task) begin
                        $display("%0t: top_task expected %0d actual %0d",
                                 $time, want.top_task, i_rsp.top_task);
                        mismatches++;
                    end
                    if (i_rsp.any_ready !== want.any_ready) begin
                        $display("%0t: any_ready expected %0d actual %0d",
                                 $time, want.any_ready, i_rsp.any_ready);
                        mismatches++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_rsp.status);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_reports.size();
    end

endmodule

// ----- verif/priority_ready_queue_tb.sv -----
// ----------------------------------------------------------------------------
// Priority ready queue testbench
// Drives insert and remove requests: a directed run through FIFO order,
// removal from head, middle and tail, duplicate and missing requests and
// level saturation, then random phases with sender gaps and receiver
// stalls. The report check predicts and compares every report.
// ----------------------------------------------------------------------------
module priority_ready_queue_tb;
    import prq_pkg::*;

    localparam int unsigned NUM_TASKS   = 8;
    localparam int unsigned NUM_LEVELS  = 10;
    localparam int          CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;

    logic [NUM_TASKS-1:0] in_queue = '0;

    prq_req_if req();
    prq_rsp_if rsp();

    priority_ready_queue #(
        .NUM_TASKS  (NUM_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    prq_queue_check #(
        .NUM_TASKS  (NUM_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) queue_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("priority_ready_queue_tb NOT OK");
            $finish;
        end
    end

    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(t_cmd op, logic [TASK_ID_W-1:0] id, logic [LEVEL_W-1:0] lvl);
        while ($urandom_range(99) < idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid   <= 1'b1;
        req.cmd     <= op;
        req.task_id <= id;
        req.level   <= lvl;
        do @(posedge i_clk); while (!req.ready);
        in_queue[id] = (op == CMD_INSERT);
    endtask

    task automatic random_request();
        t_cmd                 op;
        logic [TASK_ID_W-1:0] id;
        logic [LEVEL_W-1:0]   lvl;
        id  = TASK_ID_W'($urandom_range(NUM_TASKS - 1));
        lvl = ($urandom_range(3) == 0) ? LEVEL_W'($urandom_range(15))
                                       : LEVEL_W'($urandom_range(2));
        if ($urandom_range(99) < 12) begin
            op = t_cmd'($urandom_range(1));
        end else begin
            if (&in_queue) op = CMD_REMOVE;
            else if (in_queue == '0) op = CMD_INSERT;
            else op = t_cmd'($urandom_range(1));
            while (in_queue[id] != (op == CMD_REMOVE))
                id = TASK_ID_W'($urandom_range(NUM_TASKS - 1));
        end
        send_request(op, id, lvl);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        req.valid   <= 1'b0;
        req.cmd     <= CMD_INSERT;
        req.task_id <= '0;
        req.level   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_REMOVE, 0, 0);
        send_request(CMD_INSERT, 3, 2);
        send_request(CMD_INSERT, 3, 5);
        send_request(CMD_INSERT, 7, 15);
        send_request(CMD_INSERT, 0, 9);
        send_request(CMD_INSERT, 5, 10);
        send_request(CMD_INSERT, 1, 2);
        send_request(CMD_INSERT, 2, 2);
        send_request(CMD_INSERT, 6, 0);
        send_request(CMD_REMOVE, 6, 15);
        send_request(CMD_REMOVE, 1, 0);
        send_request(CMD_REMOVE, 3, 0);
        send_request(CMD_REMOVE, 2, 0);
        send_request(CMD_INSERT, 4, 8);
        send_request(CMD_REMOVE, 5, 0);
        send_request(CMD_REMOVE, 7, 0);
        send_request(CMD_REMOVE, 4, 0);
        send_request(CMD_REMOVE, 0, 0);
        send_request(CMD_REMOVE, 0, 0);
        send_request(CMD_INSERT, 4, 1);
        send_request(CMD_INSERT, 4, 1);
        send_request(CMD_REMOVE, 4, 1);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            repeat (150) random_request();
            drain();
        end

        repeat (NUM_LEVELS + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("priority_ready_queue_tb OK");
        else
            $display("priority_ready_queue_tb NOT OK");
        $finish;
    end

endmodule
